// File: rtl/rc4_pkg.sv
// Shared constants, types and state codes of the RC4 stream cipher.
`default_nettype none

package rc4_pkg;

  localparam int unsigned PermDepth   = 256;
  localparam int unsigned AddrW       = $clog2(PermDepth);
  localparam int unsigned ByteW       = 8;
  localparam int unsigned MaxKeyBytes = 16;
  localparam int unsigned KeyW        = MaxKeyBytes * ByteW;
  localparam int unsigned KeyLenW     = 5;
  localparam int unsigned KeyIdxW     = $clog2(MaxKeyBytes);
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 64;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgKeyLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyLen  = 2'd2;

  localparam logic [KeyLenW-1:0] KeyLenReset = KeyLenW'(MaxKeyBytes);
  localparam logic [AddrW-1:0]   LastEntry   = AddrW'(PermDepth - 1);

  // Sequencer states, one-hot
  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_FILL   = 11'b000_0000_0010,
    ST_K_RD_I = 11'b000_0000_0100,
    ST_K_RD_J = 11'b000_0000_1000,
    ST_K_WR_I = 11'b000_0001_0000,
    ST_K_WR_J = 11'b000_0010_0000,
    ST_P_RD_I = 11'b000_0100_0000,
    ST_P_RD_J = 11'b000_1000_0000,
    ST_P_WR_I = 11'b001_0000_0000,
    ST_P_DONE = 11'b010_0000_0000,
    ST_P_WAIT = 11'b100_0000_0000
  } rc4_state_e;

  // One access cycle of the permutation memory
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ByteW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } perm_req_t;

endpackage : rc4_pkg

`default_nettype wire

// File: rtl/rc4_perm_ram.sv
// Permutation memory: 256 x 8, one write port, one registered read port.
`default_nettype none

module rc4_perm_ram (
  input  wire logic                      clk_i,
  input  wire rc4_pkg::perm_req_t        req_i,
  output logic [rc4_pkg::ByteW-1:0]      rdata_o
);
  import rc4_pkg::*;

  logic [ByteW-1:0] mem [PermDepth];

  // Read returns the old contents when the same entry is written.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule : rc4_perm_ram

`default_nettype wire

// File: rtl/rc4_core.sv
// Sequencer of the RC4 cipher: table fill, key schedule, keystream and result register.
`default_nettype none

module rc4_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [rc4_pkg::KeyW-1:0]      key_i,
  input  wire logic [rc4_pkg::KeyLenW-1:0]   key_len_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [rc4_pkg::ByteW-1:0]     in_data_i,
  input  wire logic                          in_start_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [rc4_pkg::ByteW-1:0]          out_data_o,
  output rc4_pkg::perm_req_t                 req_o,
  input  wire logic [rc4_pkg::ByteW-1:0]     rdata_i
);
  import rc4_pkg::*;

  rc4_state_e         state_q, state_d;
  logic [AddrW-1:0]   i_q, i_d, j_q, j_d, cnt_q, cnt_d, t_q, t_d;
  logic [ByteW-1:0]   si_q, si_d, sj_q, sj_d;
  logic [ByteW-1:0]   data_q, data_d, res_q, res_d, out_data_q, out_data_d;
  logic [KeyIdxW-1:0] kidx_q, kidx_d;
  logic               keyed_q, keyed_d, out_valid_q, out_valid_d;

  logic [KeyLenW-1:0] klen_eff;
  logic [ByteW-1:0]   key_byte, ks, j_ksa;
  logic               slot_free;

  // Clamp the key length into 1..MaxKeyBytes
  always_comb begin
    klen_eff = key_len_i;
    if (key_len_i == '0) begin
      klen_eff = KeyLenW'(1);
    end else if (key_len_i > KeyLenW'(MaxKeyBytes)) begin
      klen_eff = KeyLenW'(MaxKeyBytes);
    end
  end

  assign key_byte  = key_i[{kidx_q, 3'b000} +: ByteW];
  assign j_ksa     = j_q + rdata_i + key_byte;
  assign slot_free = !out_valid_q || out_ready_i;

  // Keystream byte: S[j] was written last, so it wins over S[i]
  always_comb begin
    if (t_q == j_q) begin
      ks = si_q;
    end else if (t_q == i_q) begin
      ks = sj_q;
    end else begin
      ks = rdata_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    cnt_d       = cnt_q;
    t_d         = t_q;
    si_d        = si_q;
    sj_d        = sj_q;
    kidx_d      = kidx_q;
    keyed_d     = keyed_q;
    data_d      = data_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    req_o       = '0;
    req_o.raddr = i_q + AddrW'(1);
    in_ready_o  = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          data_d = in_data_i;
          if (in_start_i || !keyed_q) begin
            cnt_d   = '0;
            state_d = ST_FILL;
          end else begin
            // read S[i+1] right away
            i_d     = i_q + AddrW'(1);
            state_d = ST_P_RD_J;
          end
        end
      end
      ST_FILL: begin
        req_o.we    = 1'b1;
        req_o.waddr = cnt_q;
        req_o.wdata = cnt_q;
        cnt_d       = cnt_q + AddrW'(1);
        if (cnt_q == LastEntry) begin
          j_d     = '0;
          kidx_d  = '0;
          state_d = ST_K_RD_I;
        end
      end
      ST_K_RD_I: begin
        req_o.raddr = cnt_q;
        state_d     = ST_K_RD_J;
      end
      ST_K_RD_J: begin
        si_d        = rdata_i;
        j_d         = j_ksa;
        req_o.raddr = j_ksa;
        if ({1'b0, kidx_q} == klen_eff - KeyLenW'(1)) begin
          kidx_d = '0;
        end else begin
          kidx_d = kidx_q + KeyIdxW'(1);
        end
        state_d = ST_K_WR_I;
      end
      ST_K_WR_I: begin
        req_o.we    = 1'b1;
        req_o.waddr = cnt_q;
        req_o.wdata = rdata_i;
        state_d     = ST_K_WR_J;
      end
      ST_K_WR_J: begin
        req_o.we    = 1'b1;
        req_o.waddr = j_q;
        req_o.wdata = si_q;
        cnt_d       = cnt_q + AddrW'(1);
        if (cnt_q == LastEntry) begin
          i_d     = '0;
          j_d     = '0;
          keyed_d = 1'b1;
          state_d = ST_P_RD_I;
        end else begin
          state_d = ST_K_RD_I;
        end
      end
      ST_P_RD_I: begin
        i_d     = i_q + AddrW'(1);
        state_d = ST_P_RD_J;
      end
      ST_P_RD_J: begin
        si_d        = rdata_i;
        j_d         = j_q + rdata_i;
        req_o.raddr = j_q + rdata_i;
        state_d     = ST_P_WR_I;
      end
      ST_P_WR_I: begin
        sj_d        = rdata_i;
        req_o.we    = 1'b1;
        req_o.waddr = i_q;
        req_o.wdata = rdata_i;
        req_o.raddr = si_q + rdata_i;
        t_d         = si_q + rdata_i;
        state_d     = ST_P_DONE;
      end
      ST_P_DONE: begin
        req_o.we    = 1'b1;
        req_o.waddr = j_q;
        req_o.wdata = si_q;
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = data_q ^ ks;
          state_d     = ST_IDLE;
        end else begin
          res_d   = data_q ^ ks;
          state_d = ST_P_WAIT;
        end
      end
      ST_P_WAIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
      kidx_q      <= '0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      cnt_q       <= cnt_d;
      kidx_q      <= kidx_d;
      keyed_q     <= keyed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    si_q       <= si_d;
    sj_q       <= sj_d;
    data_q     <= data_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_start_rebuilds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_start_i |=> state_q == ST_FILL)
    else $error("start flag did not trigger a table rebuild");

  a_keyed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(keyed_q))
    else $error("keyed flag dropped outside reset");

  a_ksa_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_K_WR_J && cnt_q == LastEntry |=> keyed_q && i_q == '0 && j_q == '0)
    else $error("key schedule end did not clear indices");

  a_swap_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_P_DONE |-> req_o.we && req_o.waddr == j_q)
    else $error("swap write to S[j] missing");

  a_result_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_P_WAIT |-> out_valid_q)
    else $error("result held back while output slot was free");
`endif

endmodule : rc4_core

`default_nettype wire

// File: rtl/rc4_stream_cipher_top.sv
// Top level of the RC4 stream cipher: key registers, sequencer and permutation memory.
`default_nettype none

// RC4 byte cipher. Each beat on the slave stream carries one byte; the block
// returns that byte XORed with the next keystream byte on the master stream,
// so encryption and decryption are the same operation. A beat with tuser set,
// or the first beat after reset, first rebuilds the cipher state: a fill of
// the identity permutation, then the 256-round key schedule (read S[i], read
// S[j], write S[i], write S[j] each round), then the keystream step. A normal
// byte is paced by the single read port of the permutation memory (read
// S[i], read S[j], swap writes, read S[S[i]+S[j]]), and the block takes no
// new byte until it has finished the last one and is back in idle.
// While the output register still holds an untaken result, a finished byte
// waits in the result register; once it moves to the output register, the
// next byte may be accepted before it is taken.
// Key registers: index 0 holds key bytes 0..7, index 1 key bytes 8..15 (byte
// n at bits 8n+7..8n), index 2 the key length, where 0 acts as 1 and values
// above 16 act as 16. Write them only while the block is idle; new values
// take effect at the next rebuild. Writes to index 3 are dropped.

module rc4_stream_cipher_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rc4_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rc4_pkg::CfgDataW-1:0]  cfg_data_i,
  // slave stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // [7:0] data_in
  input  wire logic [0:0]                    s_axis_tuser,   // [0] start_msg
  // master stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [7:0]                         m_axis_tdata    // [7:0] data_out
);
  import rc4_pkg::*;

  logic [CfgDataW-1:0] key_low_q, key_high_q;
  logic [KeyLenW-1:0]  key_len_q;
  perm_req_t           perm_req;
  logic [ByteW-1:0]    perm_rdata;

  // Always take configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= KeyLenReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgKeyLow:  key_low_q  <= cfg_data_i;
        CfgKeyHigh: key_high_q <= cfg_data_i;
        CfgKeyLen:  key_len_q  <= cfg_data_i[KeyLenW-1:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  rc4_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       ({key_high_q, key_low_q}),
    .key_len_i   (key_len_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_start_i  (s_axis_tuser[0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .req_o       (perm_req),
    .rdata_i     (perm_rdata)
  );

  rc4_perm_ram u_perm_ram (
    .clk_i   (clk_i),
    .req_i   (perm_req),
    .rdata_o (perm_rdata)
  );

endmodule : rc4_stream_cipher_top

`default_nettype wire

// File: tb/sv/rc4_stream_cipher_top_tb.sv
// Self-checking testbench of the RC4 stream cipher against a local RC4 predictor.
`default_nettype none

module rc4_stream_cipher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rc4_pkg::*;

  // One pending input beat: the byte and the restart flag carried on tuser
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             start;
  } cipher_beat_t;

  // Index 3 has no register behind it; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  localparam int unsigned HoldCycles  = 400;   // long receiver hold-off
  localparam int unsigned TargetBeats = 1100;  // stop queueing random beats here
  localparam int unsigned SettleCycles = 20;   // quiet time after the last result

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;   // [7:0] data_in
  logic [0:0]          s_axis_tuser  = '0;   // [0] start_msg
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;         // [7:0] data_out

  rc4_stream_cipher_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Cipher predictor: its own copy of the key registers and the RC4 state.
  // ---------------------------------------------------------------------------
  logic [CfgDataW-1:0] key_lo_q  = '0;
  logic [CfgDataW-1:0] key_hi_q  = '0;
  logic [KeyLenW-1:0]  key_len_q = KeyLenReset;
  logic [ByteW-1:0]    sbox [PermDepth];
  logic [AddrW-1:0]    ks_i      = '0;
  logic [AddrW-1:0]    ks_j      = '0;
  logic                keyed_q   = 1'b0;

  // Identity fill, then the 256-round key schedule over the key repeated
  // cyclically; a length of 0 acts as 1 and anything above 16 acts as 16.
  function automatic void rekey();
    int unsigned      klen;
    int unsigned      n;
    logic [KeyW-1:0]  key_bits;
    logic [ByteW-1:0] jj;
    logic [ByteW-1:0] tmp;
    key_bits = {key_hi_q, key_lo_q};
    if (key_len_q == 0) begin
      klen = 1;
    end else if (key_len_q > MaxKeyBytes) begin
      klen = MaxKeyBytes;
    end else begin
      klen = key_len_q;
    end
    for (n = 0; n < PermDepth; n++) sbox[n] = n[ByteW-1:0];
    jj = '0;
    for (n = 0; n < PermDepth; n++) begin
      jj = jj + sbox[n] + key_bits[ByteW*(n % klen) +: ByteW];
      tmp = sbox[n];
      sbox[n] = sbox[jj];
      sbox[jj] = tmp;
    end
    ks_i = '0;
    ks_j = '0;
    keyed_q = 1'b1;
  endfunction

  // Advance the keystream by one byte and return the transformed data byte.
  function automatic logic [ByteW-1:0] rc4_transform(input logic [ByteW-1:0] data,
                                                     input logic start);
    logic [ByteW-1:0] tmp;
    logic [AddrW-1:0] pick;
    if (start || !keyed_q) rekey();
    ks_i = ks_i + 1'b1;
    ks_j = ks_j + sbox[ks_i];
    tmp = sbox[ks_i];
    sbox[ks_i] = sbox[ks_j];
    sbox[ks_j] = tmp;
    pick = sbox[ks_i] + sbox[ks_j];
    return data ^ sbox[pick];
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping shared by the stimulus, driver and monitor
  // ---------------------------------------------------------------------------
  cipher_beat_t     pending_beats[$];
  logic [ByteW-1:0] expected_bytes[$];
  int unsigned      beats_queued = 0;
  int unsigned      beats_taken  = 0;
  int unsigned      mismatches   = 0;
  bit               sender_idles   = 1'b1;
  bit               receiver_stalls = 1'b1;
  int unsigned      hold_asks = 0;

  // ---------------------------------------------------------------------------
  // Slave-side driver: present the next pending beat, with a random gap after
  // each one while idling is enabled. Valid is raised only once per step.
  // ---------------------------------------------------------------------------
  int unsigned  send_gap = 0;
  cipher_beat_t next_beat;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        next_beat = pending_beats.pop_front();
        s_axis_tdata  <= next_beat.data;
        s_axis_tuser  <= next_beat.start;
        s_axis_tvalid <= 1'b1;
        send_gap = sender_idles ? $urandom_range(0, 11) : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Master-side receiver: random stall per result, plus a long hold-off on
  // request so the block fills up and has to drop s_axis_tready.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  int unsigned hold_seen  = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        stall_left = receiver_stalls ? $urandom_range(0, 11) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HoldCycles;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input beat, check every output beat
  // against the oldest prediction.
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0] want_byte;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_bytes.push_back(rc4_transform(s_axis_tdata, s_axis_tuser[0]));
        beats_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected output beat, expected none, actual %02h",
                   $realtime, m_axis_tdata);
        end else begin
          want_byte = expected_bytes.pop_front();
          if (m_axis_tdata !== want_byte) begin
            mismatches++;
            $display("%0t: data_out mismatch, expected %02h, actual %02h",
                     $realtime, want_byte, m_axis_tdata);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_beat(input logic [ByteW-1:0] data, input logic start);
    cipher_beat_t b;
    b.data  = data;
    b.start = start;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // Block until every queued beat went in and every result came out.
  task automatic drain();
    while (beats_taken != beats_queued || expected_bytes.size() != 0) @(negedge clk_i);
  endtask

  // One write on the configuration channel; mirror it into the predictor
  // at the handshake. Only called while the stream is drained.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgKeyLow:  key_lo_q  = val;
      CfgKeyHigh: key_hi_q  = val;
      CfgKeyLen:  key_len_q = val[KeyLenW-1:0];
      default:    ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CfgDataW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Key length value: mostly in range, often an extreme or out of range,
  // with random upper bits that the register must ignore.
  function automatic logic [CfgDataW-1:0] rand_key_len();
    logic [CfgDataW-1:0] v;
    v = rand_word();
    case ($urandom_range(0, 6))
      0:       v[KeyLenW-1:0] = '0;
      1:       v[KeyLenW-1:0] = 5'd1;
      2:       v[KeyLenW-1:0] = 5'd16;
      3:       v[KeyLenW-1:0] = 5'($urandom_range(17, 31));
      default: v[KeyLenW-1:0] = 5'($urandom_range(1, 16));
    endcase
    if ($urandom_range(0, 1) == 0) v[CfgDataW-1:KeyLenW] = '0;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  int unsigned phase_no;
  int unsigned msg_count;
  int unsigned msg_len;
  int unsigned k;
  int unsigned m;

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset key (all zero, 16 bytes); the first beat rebuilds without tuser.
    queue_beat(8'h00, 1'b0);
    queue_beat(8'hFF, 1'b0);
    queue_beat(8'hA5, 1'b0);
    queue_beat(8'h5A, 1'b0);
    drain();

    // All-ones key words, length 0 behaves as a one-byte key.
    write_reg(CfgKeyLow, '1);
    write_reg(CfgKeyHigh, '1);
    write_reg(CfgKeyLen, '0);
    queue_beat(8'h00, 1'b1);
    queue_beat(8'hFF, 1'b0);
    queue_beat(8'h3C, 1'b0);
    drain();

    // Upper data bits dropped: the low five bits give 17, clamped to 16.
    write_reg(CfgKeyLen, 64'hFFFF_FFFF_FFFF_FFF1);
    write_reg(CfgKeyLow, '0);
    queue_beat(8'h00, 1'b1);
    queue_beat(8'hFF, 1'b0);
    queue_beat(8'h81, 1'b0);
    drain();

    // Key change in the middle of a message: old keystream continues until
    // the next restart picks up the new one-byte key.
    write_reg(CfgKeyLow, 64'h0123_4567_89AB_CDEF);
    write_reg(CfgKeyLen, 64'd1);
    queue_beat(8'h7E, 1'b0);
    queue_beat(8'h01, 1'b0);
    queue_beat(8'hFF, 1'b1);
    queue_beat(8'h00, 1'b0);
    drain();

    // Write to the unused index must be dropped; length 31 clamps to 16.
    write_reg(CfgUnused, '1);
    write_reg(CfgKeyLen, 64'd31);
    queue_beat(8'h80, 1'b0);
    queue_beat(8'h55, 1'b1);
    queue_beat(8'hAA, 1'b0);
    drain();

    write_reg(CfgKeyLen, 64'd16);
    write_reg(CfgKeyHigh, rand_word());
    queue_beat(8'hFF, 1'b1);
    queue_beat(8'h00, 1'b0);
    drain();

    // Random phases: new settings while drained, then a few messages.
    // Most messages open with a restart; some run past 256 bytes so the
    // index wraps, and a few stray restarts or continuations add noise.
    phase_no = 0;
    while (beats_queued < TargetBeats) begin
      if ($urandom_range(0, 2) != 0) write_reg(CfgKeyLow, rand_word());
      if ($urandom_range(0, 2) != 0) write_reg(CfgKeyHigh, rand_word());
      if ($urandom_range(0, 2) != 0) write_reg(CfgKeyLen, rand_key_len());
      if ($urandom_range(0, 9) == 0) write_reg(CfgUnused, rand_word());
      sender_idles    = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);

      msg_count = $urandom_range(1, 4);
      for (m = 0; m < msg_count; m++) begin
        if (beats_queued >= TargetBeats) break;
        msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(256, 300)
                                              : $urandom_range(1, 40);
        // keep the total close to the target
        if (msg_len > TargetBeats - beats_queued) msg_len = TargetBeats - beats_queued;
        queue_beat(8'($urandom), ($urandom_range(0, 9) != 0));
        for (k = 1; k < msg_len; k++)
          queue_beat(8'($urandom), ($urandom_range(0, 29) == 0));
      end

      // Hold the receiver off while the sender keeps offering beats.
      if (phase_no == 0 || $urandom_range(0, 4) == 0) hold_asks++;
      drain();
      phase_no++;
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("rc4_stream_cipher_top_tb: clean");
    end else begin
      $display("rc4_stream_cipher_top_tb: errors");
    end
    $finish;
  end

  // Watchdog, well above the slowest legal run.
  initial begin
    #20_000_000;
    $display("rc4_stream_cipher_top_tb: errors");
    $finish;
  end

endmodule : rc4_stream_cipher_top_tb

`default_nettype wire
